### src/huffman_table_stream_decoder_defines.svh
// Assertion macros shared by the decoder's checker.
`ifndef HUFFMAN_TABLE_STREAM_DECODER_DEFINES_SVH
`define HUFFMAN_TABLE_STREAM_DECODER_DEFINES_SVH

// Property that holds on every clock edge outside reset.
`define HTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication to the next cycle.
`define HTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/hts_pkg.sv
// Shared types and constants for the table-driven Huffman stream decoder.
package hts_pkg;

  localparam int NUM_CELLS     = 256;
  localparam int GROUP_SIZE    = 16;
  localparam int NUM_GROUPS    = NUM_CELLS / GROUP_SIZE;
  localparam int MAX_CODE_BITS = 32;
  localparam int CODE_W        = 32;
  localparam int IDX_W         = $clog2(NUM_CELLS);
  localparam int GIDX_W        = $clog2(NUM_GROUPS);

  localparam logic [1:0] KIND_SYM = 2'd0;
  localparam logic [1:0] KIND_OK  = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [7:0]        sym;
    logic [CODE_W-1:0] code;
    logic [7:0]        len;
  } wr_t;

  typedef struct packed {
    logic [5:0]        cnt;
    logic [CODE_W-1:0] mask;
    logic [CODE_W-1:0] bits;
    logic [IDX_W:0]    total;
  } mch_t;

  typedef enum logic [2:0] {
    PH_COUNT, PH_SYMBOL, PH_LENGTH, PH_CODE, PH_PAD, PH_PAYLOAD
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_BIT, ST_CMP, ST_GRP, ST_SEL, ST_END
  } state_t;

endpackage

### src/huffman_table_stream_decoder.sv
// Huffman stream decoder that first loads its own code table from the byte stream.
//
// Each word on the input is one byte of a message: a symbol count minus one,
// then per symbol the symbol byte, its code length and the code bytes (MSB
// first), then a padding byte giving the valid bits of the final byte, then
// the payload. Table entries live in a row of 256 cells; every cell compares
// its code against the shared bit buffer and the lowest matching cell wins
// through a priority chain, cut into 16 groups of 16 with a register after
// each group. A payload byte is accepted, then each code bit passes through
// the steps shift, cell compare, group select and final select, and a
// closing step ends the byte; the final select waits while a found symbol
// cannot go out because the output is stalled. Symbols are held one deep
// so the last result of each byte can carry run_last; a byte marked last
// adds an end word (kind 1 ok, kind 2 error) and then the decoder waits
// for a new message. A stalled output holds the decoder; no input word is
// taken until all results of the previous word are loaded for output.
module huffman_table_stream_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] symbol,
  output logic [1:0] kind,
  output logic       run_last
);

  localparam int IW = hts_pkg::IDX_W;
  localparam int CW = hts_pkg::CODE_W;

  // Control and scalar state.
  hts_pkg::state_t state, state_next;
  hts_pkg::phase_t phase, phase_next;
  logic [IW:0]   total, total_next;
  logic [7:0]    longest, longest_next;
  logic [IW-1:0] eidx, eidx_next;
  logic [5:0]    left, left_next;
  logic [CW-1:0] bits, bits_next;
  logic [5:0]    cnt, cnt_next;
  logic [3:0]    fvb, fvb_next;
  logic          err, err_next;
  logic          in_pay, in_pay_next;
  logic          last_r, last_r_next;
  logic [7:0]    sh, sh_next;
  logic [3:0]    k, k_next;
  logic [3:0]    nb, nb_next;
  logic          pend_valid, pend_valid_next;
  logic [7:0]    pend_sym, pend_sym_next;

  // Entry being parsed.
  logic [7:0]    cur_sym, cur_sym_next;
  logic [7:0]    cur_len, cur_len_next;
  logic [CW-1:0] cur_code, cur_code_next;

  // Output load.
  logic       out_load;
  logic [7:0] ld_sym;
  logic [1:0] ld_kind;
  logic       ld_rl;
  logic       out_free;

  hts_pkg::wr_t  wr;
  hts_pkg::mch_t mch;

  logic       gf [0:hts_pkg::NUM_GROUPS-1];
  logic [7:0] gs [0:hts_pkg::NUM_GROUPS-1];
  logic       cf [0:hts_pkg::NUM_GROUPS];
  logic [7:0] cs [0:hts_pkg::NUM_GROUPS];

  // Code-byte arithmetic.
  logic [8:0] code_total;
  logic [8:0] code_base;
  logic [8:0] code_rem;
  logic [3:0] take;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == hts_pkg::ST_IDLE);

  assign mch.cnt   = cnt;
  assign mch.mask  = (cnt >= 6'd32) ? {CW{1'b1}} : ((CW'(1) << cnt) - CW'(1));
  assign mch.bits  = bits;
  assign mch.total = total;

  // Cell row, in groups.
  for (genvar g = 0; g < hts_pkg::NUM_GROUPS; g++) begin : g_grp
    hts_group u_group (
      .clk  (clk),
      .gidx (hts_pkg::GIDX_W'(g)),
      .wr   (wr),
      .mch  (mch),
      .found(gf[g]),
      .sym  (gs[g])
    );
    assign cf[g] = gf[g] || cf[g+1];
    assign cs[g] = gf[g] ? gs[g] : cs[g+1];
  end
  assign cf[hts_pkg::NUM_GROUPS] = 1'b0;
  assign cs[hts_pkg::NUM_GROUPS] = 8'd0;

  assign code_total = (9'(cur_len) + 9'd7) >> 3;
  assign code_base  = (code_total - 9'(left)) << 3;
  assign code_rem   = 9'(cur_len) - code_base;
  assign take       = (code_rem > 9'd8) ? 4'd8 : code_rem[3:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= hts_pkg::ST_IDLE;
      phase      <= hts_pkg::PH_COUNT;
      total      <= '0;
      longest    <= '0;
      eidx       <= '0;
      left       <= '0;
      bits       <= '0;
      cnt        <= '0;
      fvb        <= '0;
      err        <= 1'b0;
      in_pay     <= 1'b0;
      last_r     <= 1'b0;
      k          <= '0;
      nb         <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      total      <= total_next;
      longest    <= longest_next;
      eidx       <= eidx_next;
      left       <= left_next;
      bits       <= bits_next;
      cnt        <= cnt_next;
      fvb        <= fvb_next;
      err        <= err_next;
      in_pay     <= in_pay_next;
      last_r     <= last_r_next;
      k          <= k_next;
      nb         <= nb_next;
      pend_valid <= pend_valid_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    sh       <= sh_next;
    pend_sym <= pend_sym_next;
    cur_sym  <= cur_sym_next;
    cur_len  <= cur_len_next;
    cur_code <= cur_code_next;
    if (out_load) begin
      symbol   <= ld_sym;
      kind     <= ld_kind;
      run_last <= ld_rl;
    end
  end

  always_comb begin
    state_next      = state;
    phase_next      = phase;
    total_next      = total;
    longest_next    = longest;
    eidx_next       = eidx;
    left_next       = left;
    bits_next       = bits;
    cnt_next        = cnt;
    fvb_next        = fvb;
    err_next        = err;
    in_pay_next     = in_pay;
    last_r_next     = last_r;
    sh_next         = sh;
    k_next          = k;
    nb_next         = nb;
    pend_valid_next = pend_valid;
    pend_sym_next   = pend_sym;
    cur_sym_next    = cur_sym;
    cur_len_next    = cur_len;
    cur_code_next   = cur_code;
    out_load        = 1'b0;
    ld_sym          = 8'd0;
    ld_kind         = hts_pkg::KIND_SYM;
    ld_rl           = 1'b0;
    wr.en           = 1'b0;
    wr.idx          = eidx;
    wr.sym          = cur_sym;
    wr.code         = cur_code;
    wr.len          = cur_len;

    unique case (state)
      hts_pkg::ST_IDLE: begin
        if (in_valid) begin
          in_pay_next = (phase == hts_pkg::PH_PAYLOAD);
          last_r_next = last_byte;
          state_next  = last_byte ? hts_pkg::ST_END : hts_pkg::ST_IDLE;
          case (phase)
            hts_pkg::PH_SYMBOL: begin
              cur_sym_next = data_byte;
              phase_next   = hts_pkg::PH_LENGTH;
            end
            hts_pkg::PH_LENGTH: begin
              cur_len_next  = data_byte;
              cur_code_next = '0;
              if (data_byte > 8'(hts_pkg::MAX_CODE_BITS)) begin
                err_next = 1'b1;
              end
              if (data_byte > longest) begin
                longest_next = data_byte;
              end
              left_next = 6'((9'(data_byte) + 9'd7) >> 3);
              if (data_byte == 8'd0) begin
                // Zero-length entry: store it and move on.
                wr.en   = 1'b1;
                wr.len  = data_byte;
                wr.code = '0;
                if ({1'b0, eidx} + (IW+1)'(1) >= total) begin
                  phase_next = hts_pkg::PH_PAD;
                end else begin
                  eidx_next  = eidx + IW'(1);
                  phase_next = hts_pkg::PH_SYMBOL;
                end
              end else begin
                phase_next = hts_pkg::PH_CODE;
              end
            end
            hts_pkg::PH_CODE: begin
              cur_code_next = (cur_code << take) | CW'(data_byte >> (4'd8 - take));
              left_next     = left - 6'd1;
              if (left == 6'd1) begin
                wr.en   = 1'b1;
                wr.code = cur_code_next;
                if ({1'b0, eidx} + (IW+1)'(1) >= total) begin
                  phase_next = hts_pkg::PH_PAD;
                end else begin
                  eidx_next  = eidx + IW'(1);
                  phase_next = hts_pkg::PH_SYMBOL;
                end
              end
            end
            hts_pkg::PH_PAD: begin
              fvb_next   = (data_byte > 8'd8) ? 4'd8 : data_byte[3:0];
              phase_next = hts_pkg::PH_PAYLOAD;
            end
            hts_pkg::PH_PAYLOAD: begin
              sh_next    = data_byte;
              k_next     = 4'd0;
              nb_next    = (last_byte && fvb != 4'd0) ? fvb : 4'd8;
              state_next = hts_pkg::ST_BIT;
            end
            default: begin
              // Symbol count: start a new message.
              longest_next = '0;
              eidx_next    = '0;
              left_next    = '0;
              bits_next    = '0;
              cnt_next     = '0;
              fvb_next     = '0;
              err_next     = 1'b0;
              total_next   = (IW+1)'(data_byte) + (IW+1)'(1);
              phase_next   = hts_pkg::PH_SYMBOL;
            end
          endcase
        end
      end

      hts_pkg::ST_BIT: begin
        if (err) begin
          state_next = hts_pkg::ST_END;
        end else if ({2'b00, cnt} >= longest || cnt == 6'd63) begin
          // No code matched within the longest length.
          err_next   = 1'b1;
          state_next = hts_pkg::ST_END;
        end else begin
          bits_next  = {bits[CW-2:0], sh[7]};
          sh_next    = {sh[6:0], 1'b0};
          cnt_next   = cnt + 6'd1;
          state_next = hts_pkg::ST_CMP;
        end
      end

      hts_pkg::ST_CMP: begin
        state_next = hts_pkg::ST_GRP;
      end

      hts_pkg::ST_GRP: begin
        state_next = hts_pkg::ST_SEL;
      end

      hts_pkg::ST_SEL: begin
        if (!(cf[0] && pend_valid && !out_free)) begin
          if (cf[0]) begin
            if (pend_valid) begin
              out_load = 1'b1;
              ld_sym   = pend_sym;
            end
            pend_valid_next = 1'b1;
            pend_sym_next   = cs[0];
            bits_next       = '0;
            cnt_next        = '0;
          end
          k_next     = k + 4'd1;
          state_next = (k + 4'd1 == nb) ? hts_pkg::ST_END : hts_pkg::ST_BIT;
        end
      end

      hts_pkg::ST_END: begin
        if (pend_valid) begin
          if (out_free) begin
            out_load        = 1'b1;
            ld_sym          = pend_sym;
            ld_rl           = !last_r;
            pend_valid_next = 1'b0;
          end
        end else if (last_r) begin
          if (out_free) begin
            out_load     = 1'b1;
            ld_kind      = (in_pay && !err) ? hts_pkg::KIND_OK : hts_pkg::KIND_ERR;
            ld_rl        = 1'b1;
            // Return the message state to its reset values (in_pay, last_r, k and nb are kept).
            phase_next   = hts_pkg::PH_COUNT;
            total_next   = '0;
            longest_next = '0;
            eidx_next    = '0;
            left_next    = '0;
            bits_next    = '0;
            cnt_next     = '0;
            fvb_next     = '0;
            err_next     = 1'b0;
            state_next   = hts_pkg::ST_IDLE;
          end
        end else begin
          state_next = hts_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = hts_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### src/hts_cell.sv
// One table entry cell: holds a code, registers its match and passes the priority chain on.
module hts_cell (
  input  logic                       clk,
  input  logic [hts_pkg::IDX_W-1:0]  idx,
  input  hts_pkg::wr_t               wr,
  input  hts_pkg::mch_t              mch,
  input  logic                       found_in,
  input  logic [7:0]                 sym_in,
  output logic                       found_out,
  output logic [7:0]                 sym_out
);

  logic [7:0]                sym;
  logic [7:0]                len;
  logic [hts_pkg::CODE_W-1:0] code;
  logic                      hit;

  always_ff @(posedge clk) begin
    if (wr.en && wr.idx == idx) begin
      sym  <= wr.sym;
      code <= wr.code;
      len  <= wr.len;
    end
    hit <= ({1'b0, idx} < mch.total) && (len == {2'b00, mch.cnt}) &&
           ((code & mch.mask) == mch.bits);
  end

  // Lower index wins: take over the chain when this entry hits.
  assign found_out = hit || found_in;
  assign sym_out   = hit ? sym : sym_in;

endmodule

### src/hts_group.sv
// Group of chained entry cells with a registered group winner.
module hts_group (
  input  logic                       clk,
  input  logic [hts_pkg::GIDX_W-1:0] gidx,
  input  hts_pkg::wr_t               wr,
  input  hts_pkg::mch_t              mch,
  output logic                       found,
  output logic [7:0]                 sym
);

  logic       f [0:hts_pkg::GROUP_SIZE];
  logic [7:0] s [0:hts_pkg::GROUP_SIZE];

  assign f[hts_pkg::GROUP_SIZE] = 1'b0;
  assign s[hts_pkg::GROUP_SIZE] = 8'd0;

  for (genvar i = 0; i < hts_pkg::GROUP_SIZE; i++) begin : g_cell
    hts_cell u_cell (
      .clk      (clk),
      .idx      (hts_pkg::IDX_W'(int'(gidx) * hts_pkg::GROUP_SIZE + i)),
      .wr       (wr),
      .mch      (mch),
      .found_in (f[i+1]),
      .sym_in   (s[i+1]),
      .found_out(f[i]),
      .sym_out  (s[i])
    );
  end

  always_ff @(posedge clk) begin
    found <= f[0];
    sym   <= s[0];
  end

endmodule

### src/hts_checker.sv
// Port-level checker for the decoder, bound to the top level.
`include "huffman_table_stream_decoder_defines.svh"

module hts_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       last_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] symbol,
  input logic [1:0] kind,
  input logic       run_last
);

  `HTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(symbol) && $stable(kind) && $stable(run_last), "output word changed while stalled")
  `HTS_ASSERT(a_kind_legal, !out_valid || kind == hts_pkg::KIND_SYM || kind == hts_pkg::KIND_OK || kind == hts_pkg::KIND_ERR, "illegal result kind")
  `HTS_ASSERT(a_end_word, !out_valid || kind == hts_pkg::KIND_SYM || (run_last && symbol == 8'd0), "end word must close the run with a zero symbol")
  `HTS_ASSERT_NEXT(a_busy_after_last, in_valid && in_ready && last_byte, !in_ready, "input taken right after the last byte")

endmodule

bind huffman_table_stream_decoder hts_checker u_hts_checker (.*);
